// ----- sv/adg_pkg.sv -----
`timescale 1ns / 1ps

package adg_pkg;

    // fixed field widths of the ports
    localparam int TS_W        = 48;
    localparam int THR_W       = 24;
    localparam int DROP_W      = 8;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int AVG_W       = 49;
    localparam int ACC_W       = 56;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_W       = 52;
    localparam int OUT_TDATA_W = 56;

    // quotient bits resolved per divider stage
    localparam int DIV_STEPS = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LATE_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DROPS      = 1'b1;

    // reset values of the registers
    localparam logic [THR_W-1:0]  THR_RESET  = 24'd800000;
    localparam logic [DROP_W-1:0] MAXD_RESET = 8'd50;

    // word kinds on tuser
    localparam logic CMD_VIDEO = 1'b0;
    localparam logic CMD_AUDIO = 1'b1;

    // accepted desync saturation bounds
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // sideband that travels with each audio word down the pipeline
    typedef struct packed {
        logic vld;
        logic avg_ok;
        logic resync;
        logic neg;
    } tag_t;

endpackage

// ----- sv/adg_ram.sv -----
`timescale 1ns / 1ps

module adg_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/adg_div.sv -----
`timescale 1ns / 1ps

module adg_div #(
    parameter int WIDTH   = 56,
    parameter int DIVISOR = 100
) (
    input  logic               clk,
    input  logic               rst_n,
    input  adg_pkg::tag_t      in_tag,
    input  logic [WIDTH-1:0]   in_data,
    output adg_pkg::tag_t      out_tag,
    output logic [WIDTH-1:0]   out_quo
);

    localparam int STEPS = adg_pkg::DIV_STEPS;
    localparam int NST   = (WIDTH + STEPS - 1) / STEPS;
    localparam int PW    = NST * STEPS;
    localparam int RW    = $clog2(DIVISOR) + 1;

    adg_pkg::tag_t   tag_w  [0:NST];
    logic [PW-1:0]   word_w [0:NST];
    logic [RW-1:0]   rem_w  [0:NST-1];

    assign tag_w[0]  = in_tag;
    assign word_w[0] = PW'(in_data);
    assign rem_w[0]  = '0;

    // restoring division, quotient bits shift in as dividend bits shift out
    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        logic [PW-1:0]  word_next;
        logic [RW-1:0]  rem_next;
        logic [RW-1:0]  trial;
        logic [PW-1:0]  word_reg;
        adg_pkg::tag_t  tag_reg;

        always_comb
        begin
            word_next = word_w[s];
            rem_next  = rem_w[s];
            trial     = '0;
            for (int k = 0; k < STEPS; k++)
            begin
                trial     = {rem_next[RW-2:0], word_next[PW-1]};
                word_next = {word_next[PW-2:0], 1'b0};
                if (trial >= RW'(DIVISOR))
                begin
                    trial        = trial - RW'(DIVISOR);
                    word_next[0] = 1'b1;
                end
                rem_next = trial;
            end
        end

        // stage sideband
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg <= '0;
            end
            else
            begin
                tag_reg <= tag_w[s];
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            word_reg <= word_next;
        end

        assign tag_w[s+1]  = tag_reg;
        assign word_w[s+1] = word_reg;

        // partial remainder, not needed after the last stage
        if (s < NST - 1)
        begin : g_rem
            logic [RW-1:0] rem_reg;

            always_ff @(posedge clk)
            begin
                rem_reg <= rem_next;
            end

            assign rem_w[s+1] = rem_reg;
        end
    end

    assign out_tag = tag_w[NST];
    assign out_quo = word_w[NST][WIDTH-1:0];

endmodule

// ----- sv/av_desync_audio_drop_gate.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake            contents
// s_*       in   s_tvalid/s_tready    tdata: timestamp, resync_request; tuser: command
// m_*       out  m_tvalid/m_tready    tdata: play, average_desync, average_valid,
//                                     desync_accepted
// cfg_*     in   cfg_we               cfg_index, cfg_wdata (write only)
//
// one input word per cycle while s_tready is high; an audio word's result passes p0, p1, p2,
// NST = ceil(SUM_W / 8) divider stages and p3 into the result queue
// the window RAM is read at the replaced entry as the new entry is written, one per cycle
// reset clears all control state; the window RAM needs no clearing pass
// s_tready drops only when FDEPTH audio words are in flight or queued unread

module av_desync_audio_drop_gate #(
    parameter int WINDOW  = 100,
    parameter int TS_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // timestamp [47:0], resync_request [48], zero pad
    input  logic [adg_pkg::IN_TDATA_W-1:0]    s_tdata,
    // command [0]
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // play [0], average_desync [49:1], average_valid [50], desync_accepted [51], zero pad
    output logic [adg_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [adg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adg_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int AW     = $clog2(WINDOW);
    localparam int FW     = $clog2(WINDOW + 1);
    localparam int DIFF_W = TS_BITS + 1;
    localparam int SUM_W  = DIFF_W + $clog2(WINDOW);
    localparam int CMP_W  = ((SUM_W > adg_pkg::ACC_W) ? SUM_W : adg_pkg::ACC_W) + 2;
    localparam int NST    = (SUM_W + adg_pkg::DIV_STEPS - 1) / adg_pkg::DIV_STEPS;
    localparam int FDEPTH = 2 ** $clog2(NST + 8);
    localparam int FPW    = $clog2(FDEPTH);
    localparam int CNT_W  = FPW + 1;
    localparam int ACC_W  = adg_pkg::ACC_W;
    localparam int OUT_W  = adg_pkg::OUT_W;

    // configuration
    logic [adg_pkg::THR_W-1:0]  thr_reg;
    logic [adg_pkg::DROP_W-1:0] maxd_reg;

    // input side
    logic                 accept;
    logic                 is_audio;
    logic                 resync;
    logic                 push;
    logic                 full;
    logic [TS_BITS-1:0]   ts;
    logic [DIFF_W-1:0]    diff;
    logic [AW-1:0]        waddr;
    logic [DIFF_W-1:0]    old_diff;

    // window bookkeeping
    logic [TS_BITS-1:0]   last_video_reg;
    logic                 video_seen_reg;
    logic [FW-1:0]        fill_reg;
    logic [AW-1:0]        oldest_reg;

    // pipeline
    adg_pkg::tag_t        p0_tag_reg;
    logic                 p0_push_reg;
    logic                 p0_full_reg;
    logic [DIFF_W-1:0]    p0_diff_reg;
    adg_pkg::tag_t        p1_tag_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [SUM_W-1:0]     diff_ext;
    logic [SUM_W-1:0]     old_ext;
    adg_pkg::tag_t        p2_tag_reg;
    logic [SUM_W-1:0]     p2_mag_reg;
    adg_pkg::tag_t        div_tag;
    logic [SUM_W-1:0]     div_quo;
    adg_pkg::tag_t        p3_tag_reg;
    logic signed [SUM_W-1:0] p3_avg_reg;

    // decision
    logic [adg_pkg::DROP_W-1:0] run_reg;
    logic [adg_pkg::DROP_W-1:0] run_next;
    logic [adg_pkg::DROP_W-1:0] run_cur;
    logic [adg_pkg::DROP_W-1:0] run_inc;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    acc_cur;
    logic signed [CMP_W-1:0]    avg_c;
    logic signed [CMP_W-1:0]    acc_c;
    logic signed [CMP_W-1:0]    thr_c;
    logic signed [CMP_W-1:0]    limit_c;
    logic signed [CMP_W-1:0]    acc_sum;
    logic                       acc_ovf;
    logic                       play;
    logic                       accepted;
    logic [adg_pkg::AVG_W-1:0]  avg_field;
    logic [OUT_W-1:0]           out_word;

    // result queue and credit
    logic [OUT_W-1:0]     fifo_mem [0:FDEPTH-1];
    logic [CNT_W-1:0]     wr_ptr_reg;
    logic [CNT_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     cred_reg;
    logic                 pop;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= adg_pkg::THR_RESET;
            maxd_reg <= adg_pkg::MAXD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                adg_pkg::REG_LATE_THRESHOLD: thr_reg  <= cfg_wdata[adg_pkg::THR_W-1:0];
                adg_pkg::REG_MAX_DROPS:      maxd_reg <= cfg_wdata[adg_pkg::DROP_W-1:0];
            endcase
        end
    end

    // input decode and window addressing
    assign accept   = s_tvalid && s_tready;
    assign is_audio = (s_tuser[0] == adg_pkg::CMD_AUDIO);
    assign resync   = s_tdata[adg_pkg::TS_W];
    assign ts       = TS_BITS'(s_tdata[adg_pkg::TS_W-1:0]);
    assign full     = (fill_reg == FW'(WINDOW));
    assign push     = accept && is_audio && video_seen_reg;
    assign diff     = {1'b0, last_video_reg} - {1'b0, ts};
    assign waddr    = full ? oldest_reg : fill_reg[AW-1:0];

    adg_ram #(
        .WIDTH (DIFF_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (push),
        .waddr (waddr),
        .wdata (diff),
        .raddr (oldest_reg),
        .rdata (old_diff)
    );

    // video timestamp, fill count and oldest pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_video_reg <= '0;
            video_seen_reg <= 1'b0;
            fill_reg       <= '0;
            oldest_reg     <= '0;
        end
        else
        begin
            if (accept && !is_audio)
            begin
                last_video_reg <= ts;
                video_seen_reg <= 1'b1;
            end
            if (push)
            begin
                if (!full)
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
                else if (oldest_reg == AW'(WINDOW - 1))
                begin
                    oldest_reg <= '0;
                end
                else
                begin
                    oldest_reg <= oldest_reg + AW'(1);
                end
            end
        end
    end

    // running sum, read data of the replaced entry arrives in the next cycle, alongside p0
    assign diff_ext = {{(SUM_W-DIFF_W){p0_diff_reg[DIFF_W-1]}}, p0_diff_reg};
    assign old_ext  = {{(SUM_W-DIFF_W){old_diff[DIFF_W-1]}}, old_diff};

    always_comb
    begin
        sum_next = sum_reg;
        if (p0_push_reg)
        begin
            if (p0_full_reg)
            begin
                sum_next = sum_reg - old_ext + diff_ext;
            end
            else
            begin
                sum_next = sum_reg + diff_ext;
            end
        end
    end

    // pipeline control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_tag_reg  <= '0;
            p0_push_reg <= 1'b0;
            p0_full_reg <= 1'b0;
            p1_tag_reg  <= '0;
            sum_reg     <= '0;
            p2_tag_reg  <= '0;
            p3_tag_reg  <= '0;
            run_reg     <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            // fields from the top: vld, avg_ok, resync, neg
            p0_tag_reg        <= {accept && is_audio, push && full, resync, 1'b0};
            p0_push_reg       <= push;
            p0_full_reg       <= full;
            p1_tag_reg        <= p0_tag_reg;
            sum_reg           <= sum_next;
            p2_tag_reg        <= {p1_tag_reg.vld, p1_tag_reg.avg_ok, p1_tag_reg.resync,
                                  sum_reg[SUM_W-1]};
            p3_tag_reg        <= div_tag;
            run_reg           <= run_next;
            acc_reg           <= acc_next;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        p0_diff_reg <= diff;
        p2_mag_reg  <= sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
        p3_avg_reg  <= div_tag.neg ? signed'(~div_quo + SUM_W'(1)) : signed'(div_quo);
    end

    adg_div #(
        .WIDTH   (SUM_W),
        .DIVISOR (WINDOW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (p2_tag_reg),
        .in_data (p2_mag_reg),
        .out_tag (div_tag),
        .out_quo (div_quo)
    );

    // lateness decision, resync clears the run first
    assign run_cur = p3_tag_reg.resync ? '0 : run_reg;
    assign acc_cur = p3_tag_reg.resync ? '0 : acc_reg;
    assign run_inc = run_cur + adg_pkg::DROP_W'(1);
    assign avg_c   = CMP_W'(p3_avg_reg);
    assign acc_c   = CMP_W'(acc_cur);
    assign thr_c   = CMP_W'(thr_reg);
    assign limit_c = thr_c + acc_c;
    assign acc_sum = acc_c + avg_c;
    assign acc_ovf = (acc_sum[CMP_W-1:ACC_W-1] != '0) && (acc_sum[CMP_W-1:ACC_W-1] != '1);

    always_comb
    begin
        play     = 1'b1;
        accepted = 1'b0;
        run_next = run_reg;
        acc_next = acc_reg;
        if (p3_tag_reg.vld)
        begin
            run_next = run_cur;
            acc_next = acc_cur;
            if (p3_tag_reg.avg_ok)
            begin
                // between the threshold and the accepted desync nothing changes
                if (avg_c > limit_c)
                begin
                    if (run_inc < maxd_reg)
                    begin
                        play     = 1'b0;
                        run_next = run_inc;
                    end
                    else
                    begin
                        run_next = '0;
                        accepted = 1'b1;
                        if (acc_ovf)
                        begin
                            acc_next = acc_sum[CMP_W-1] ? adg_pkg::ACC_MIN : adg_pkg::ACC_MAX;
                        end
                        else
                        begin
                            acc_next = acc_sum[ACC_W-1:0];
                        end
                    end
                end
                else if (avg_c < thr_c)
                begin
                    run_next = '0;
                    acc_next = '0;
                end
            end
        end
    end

    assign avg_field = p3_tag_reg.avg_ok ? avg_c[adg_pkg::AVG_W-1:0] : '0;
    assign out_word  = {accepted, p3_tag_reg.avg_ok, avg_field, play};

    // result queue
    always_ff @(posedge clk)
    begin
        if (p3_tag_reg.vld)
        begin
            fifo_mem[wr_ptr_reg[FPW-1:0]] <= out_word;
        end
    end

    assign m_tvalid = (wr_ptr_reg != rd_ptr_reg);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {{(adg_pkg::OUT_TDATA_W-OUT_W){1'b0}}, fifo_mem[rd_ptr_reg[FPW-1:0]]};

    // queue pointers and credit for audio words in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cred_reg   <= '0;
        end
        else
        begin
            if (p3_tag_reg.vld)
            begin
                wr_ptr_reg <= wr_ptr_reg + CNT_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
            end
            cred_reg <= cred_reg + CNT_W'(accept && is_audio) - CNT_W'(pop);
        end
    end

    assign s_tready = (cred_reg != CNT_W'(FDEPTH));

    // queue never written when full
    a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
        p3_tag_reg.vld |-> ((wr_ptr_reg - rd_ptr_reg) != CNT_W'(FDEPTH)))
        else $error("result queue written while full");

    // queued words never outnumber the credit
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) <= cred_reg)
        else $error("queue holds more words than credit allows");

    // fill count stays within the window
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(WINDOW))
        else $error("window fill beyond depth");

    // a drop only follows a valid average
    a_drop_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> m_tdata[50])
        else $error("dropped word without an average");

    // accepting the desync always plays the word
    a_accept_play: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[51]) |-> (m_tdata[0] && m_tdata[50]))
        else $error("accepted desync on a dropped or averageless word");

endmodule

// ----- tb/sv/adg_gate_monitor.sv -----
`timescale 1ns / 1ps

module adg_gate_monitor #(
    parameter int WINDOW = 100
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // timestamp [47:0], resync_request [48], zero pad
    input  logic [adg_pkg::IN_TDATA_W-1:0]  s_tdata,
    // command [0]
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // play [0], average_desync [49:1], average_valid [50], desync_accepted [51], zero pad
    input  logic [adg_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [adg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adg_pkg::CFG_W-1:0]       cfg_wdata,
    output int                              fails,
    output int                              pending
);

    localparam int TSW    = adg_pkg::TS_W;
    localparam int QDEPTH = 256;

    // result word as laid out on m_tdata, lowest field last
    typedef struct packed {
        logic                             absorbed;
        logic                             avg_ok;
        logic signed [adg_pkg::AVG_W-1:0] avg;
        logic                             play;
    } gate_verdict_t;

    // register copies
    logic [adg_pkg::THR_W-1:0]  late_thr;
    logic [adg_pkg::DROP_W-1:0] drop_limit;

    // gate state
    logic [TSW-1:0]      video_ts;
    logic                video_known;
    logic [63:0]         diff_hist [WINDOW];
    int                  fill_cnt;
    int                  oldest_idx;
    logic [63:0]         diff_sum;
    logic [7:0]          drop_run;
    logic signed [63:0]  absorbed_lag;

    // expected words in order, ring of indexes
    gate_verdict_t       verdict_buf [QDEPTH];
    int                  q_head;
    int                  q_tail;
    int                  bad_words;

    // verdict for one audio word, updating the gate state
    task automatic judge_audio(input logic [TSW-1:0] ts, input logic resync,
                               output gate_verdict_t v);
        logic [63:0]        diff;
        logic [63:0]        mag;
        logic [63:0]        quo;
        logic signed [63:0] avg;
        logic signed [63:0] thr_s;
        logic signed [63:0] total;
        logic signed [63:0] acc_hi;
        logic signed [63:0] acc_lo;

        v      = '0;
        v.play = 1'b1;
        acc_hi = adg_pkg::ACC_MAX;
        acc_lo = adg_pkg::ACC_MIN;
        if (resync)
        begin
            drop_run     = '0;
            absorbed_lag = '0;
        end
        if (video_known)
        begin
            diff = {16'd0, video_ts} - {16'd0, ts};
            if (fill_cnt < WINDOW)
            begin
                diff_hist[fill_cnt] = diff;
                fill_cnt++;
                diff_sum += diff;
            end
            else
            begin
                diff_sum = diff_sum - diff_hist[oldest_idx] + diff;
                diff_hist[oldest_idx] = diff;
                oldest_idx = (oldest_idx + 1) % WINDOW;

                // average truncated toward zero
                mag   = diff_sum[63] ? 64'd0 - diff_sum : diff_sum;
                quo   = mag / 64'(WINDOW);
                avg   = diff_sum[63] ? 64'd0 - quo : quo;
                v.avg_ok = 1'b1;
                v.avg    = avg[adg_pkg::AVG_W-1:0];

                thr_s = $signed({40'd0, late_thr});
                if (avg > thr_s + absorbed_lag)
                begin
                    drop_run = drop_run + 8'd1;
                    if (drop_run < drop_limit)
                        v.play = 1'b0;
                    else
                    begin
                        // absorb the lag, saturating
                        total = absorbed_lag + avg;
                        if (total > acc_hi)
                            total = acc_hi;
                        if (total < acc_lo)
                            total = acc_lo;
                        absorbed_lag = total;
                        drop_run     = '0;
                        v.absorbed   = 1'b1;
                    end
                end
                else if (avg < thr_s)
                begin
                    drop_run     = '0;
                    absorbed_lag = '0;
                end
            end
        end
    endtask

    // watch config, input and result channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        gate_verdict_t want;
        gate_verdict_t seen;

        if (!rst_n)
        begin
            late_thr     = adg_pkg::THR_RESET;
            drop_limit   = adg_pkg::MAXD_RESET;
            video_ts     = '0;
            video_known  = 1'b0;
            fill_cnt     = 0;
            oldest_idx   = 0;
            diff_sum     = '0;
            drop_run     = '0;
            absorbed_lag = '0;
            q_head       = 0;
            q_tail       = 0;
            bad_words    = 0;
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    adg_pkg::REG_LATE_THRESHOLD: late_thr   = cfg_wdata[adg_pkg::THR_W-1:0];
                    adg_pkg::REG_MAX_DROPS:      drop_limit = cfg_wdata[adg_pkg::DROP_W-1:0];
                    default: ;
                endcase
            end

            // accepted input word
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == adg_pkg::CMD_VIDEO)
                begin
                    video_ts    = s_tdata[TSW-1:0];
                    video_known = 1'b1;
                end
                else
                begin
                    judge_audio(s_tdata[TSW-1:0], s_tdata[TSW], want);
                    verdict_buf[q_tail % QDEPTH] = want;
                    q_tail++;
                end
            end

            // accepted result word
            if (m_tvalid && m_tready)
            begin
                seen = m_tdata[adg_pkg::OUT_W-1:0];
                if (q_tail == q_head)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("%0t: unexpected word play=%0b avg=%0d valid=%0b acc=%0b",
                                 $time, seen.play, seen.avg, seen.avg_ok, seen.absorbed);
                end
                else
                begin
                    want = verdict_buf[q_head % QDEPTH];
                    q_head++;
                    if (seen.play !== want.play || seen.avg !== want.avg ||
                        seen.avg_ok !== want.avg_ok || seen.absorbed !== want.absorbed)
                    begin
                        bad_words++;
                        if (bad_words <= 10)
                        begin
                            $display("%0t: word mismatch exp play=%0b avg=%0d valid=%0b acc=%0b",
                                     $time, want.play, want.avg, want.avg_ok, want.absorbed);
                            $display("    got play=%0b avg=%0d valid=%0b acc=%0b",
                                     seen.play, seen.avg, seen.avg_ok, seen.absorbed);
                        end
                    end
                end
            end

            fails   <= bad_words;
            pending <= q_tail - q_head;
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int          TSW           = adg_pkg::TS_W;
    localparam int          THRW          = adg_pkg::THR_W;
    localparam int          DRW           = adg_pkg::DROP_W;
    localparam int          CFGW          = adg_pkg::CFG_W;
    localparam int          INW           = adg_pkg::IN_TDATA_W;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam logic [47:0] TS_MAX        = {TSW{1'b1}};

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [INW-1:0]                  s_tdata   = '0;
    logic [0:0]                      s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [adg_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            cfg_we    = 1'b0;
    logic [adg_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFGW-1:0]                 cfg_wdata = '0;

    int                     mon_fails;
    int                     mon_pending;
    int                     cycles    = 0;
    int                     rdy_left  = 0;
    bit                     calm      = 1'b0;
    logic [TSW-1:0]         vid_ts    = '0;

    av_desync_audio_drop_gate DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    adg_gate_monitor u_monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fails     (mon_fails),
        .pending   (mon_pending)
    );

    // clock
    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin : sink_stall
        int r;

        r = $urandom_range(0, 99);
        if (rdy_left > 0)
            rdy_left <= rdy_left - 1;
        else if (calm)
            m_tready <= 1'b1;
        else if (r < 65)
        begin
            m_tready <= 1'b1;
            rdy_left <= $urandom_range(0, 6);
        end
        else if (r < 95)
        begin
            m_tready <= 1'b0;
            rdy_left <= $urandom_range(0, 3);
        end
        else
        begin
            m_tready <= 1'b0;
            rdy_left <= $urandom_range(10, 40);
        end
    end

    function automatic logic [TSW-1:0] rand_ts();
        return TSW'({$urandom, $urandom});
    endfunction

    // one input word, with a random gap ahead of it
    task automatic send_word(input logic cmd, input logic [TSW-1:0] ts, input logic resync);
        int r;
        int gap;

        r   = $urandom_range(0, 99);
        gap = 0;
        if (!calm)
        begin
            if (r >= 92)
                gap = $urandom_range(8, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(INW-TSW-1){1'b0}}, resync, ts};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // hold off until every result is back and the pipe has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (mon_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [THRW-1:0] thr, input logic [DRW-1:0] maxd);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= adg_pkg::REG_LATE_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_index <= adg_pkg::REG_MAX_DROPS;
        cfg_wdata <= {{(CFGW-DRW){1'b0}}, maxd};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // random words shaped around the lateness threshold
    task automatic run_phase(input int count, input logic [THRW-1:0] thr,
                             input logic [DRW-1:0] maxd);
        int              seg_left;
        int              mode;
        int              r;
        logic [TSW-1:0]  lag;
        logic [TSW-1:0]  step;
        logic [TSW-1:0]  jit;

        seg_left = 0;
        mode     = 0;
        lag      = '0;
        step     = '0;
        for (int i = 0; i < count; i++)
        begin
            // new lateness segment
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 80);
                mode     = $urandom_range(0, 6);
                calm     = ($urandom_range(0, 4) == 0);
                case (mode)
                    0: lag = TSW'($urandom_range(0, thr / 2));
                    1: lag = TSW'(thr + $urandom_range(1, 3000));
                    2:
                    begin
                        lag      = TSW'(2 * thr + $urandom_range(1000, 100000));
                        seg_left = (maxd + 20) * 4 / 3 + $urandom_range(0, 40);
                    end
                    3:
                    begin
                        lag  = TSW'(thr / 2);
                        step = TSW'(thr / 32 + $urandom_range(50, 4000));
                    end
                    4: lag = '0 - TSW'($urandom_range(1, 2000000));
                    5: lag = rand_ts();
                    default: lag = TSW'(thr);
                endcase
            end
            seg_left--;

            r = $urandom_range(0, 99);
            if (r < 4)
                send_word(1'($urandom_range(0, 1)), rand_ts(), 1'($urandom_range(0, 1)));
            else if (r < 22)
            begin
                vid_ts = vid_ts + TSW'($urandom_range(1, 400000));
                send_word(adg_pkg::CMD_VIDEO, vid_ts, 1'($urandom_range(0, 1)));
            end
            else
            begin
                if (mode == 6)
                    jit = TSW'($urandom_range(0, 2)) - 1;
                else
                    jit = TSW'($urandom_range(0, 255));
                send_word(adg_pkg::CMD_AUDIO, vid_ts - lag - jit, $urandom_range(0, 39) == 0);
                if (mode == 3)
                    lag = lag + step;
            end

            // now and then let everything drain mid-stream
            if ($urandom_range(0, 299) == 0)
                wait_idle();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, resync, audio before video, window filling
        send_word(adg_pkg::CMD_AUDIO, '0, 1'b1);
        send_word(adg_pkg::CMD_AUDIO, TS_MAX, 1'b0);
        send_word(adg_pkg::CMD_VIDEO, TS_MAX, 1'b1);
        send_word(adg_pkg::CMD_AUDIO, '0, 1'b0);
        send_word(adg_pkg::CMD_AUDIO, TS_MAX, 1'b1);
        send_word(adg_pkg::CMD_VIDEO, '0, 1'b0);
        send_word(adg_pkg::CMD_AUDIO, TS_MAX, 1'b0);
        send_word(adg_pkg::CMD_AUDIO, '0, 1'b1);
        send_word(adg_pkg::CMD_VIDEO, 48'hAAAA_AAAA_AAAA, 1'b1);
        send_word(adg_pkg::CMD_AUDIO, 48'h5555_5555_5555, 1'b0);
        send_word(adg_pkg::CMD_AUDIO, 48'hAAAA_AAAA_AAAA, 1'b1);
        vid_ts = 48'h0000_1000_0000;
        send_word(adg_pkg::CMD_VIDEO, vid_ts, 1'b0);
        for (int i = 0; i < 8; i++)
            send_word(adg_pkg::CMD_AUDIO, vid_ts - 48'd900000 + 48'(i * 50000), i == 4);

        // random phases across register settings, extremes included
        set_config('0, 8'd1);
        run_phase(250, '0, 8'd1);
        set_config({THRW{1'b1}}, 8'd255);
        run_phase(400, {THRW{1'b1}}, 8'd255);
        begin : mid_phases
            logic [THRW-1:0] thr;
            logic [DRW-1:0]  maxd;

            thr  = THRW'($urandom_range(500, 20000));
            maxd = DRW'($urandom_range(2, 6));
            set_config(thr, maxd);
            run_phase(250, thr, maxd);
            thr  = THRW'($urandom_range(0, 16777215));
            maxd = DRW'($urandom_range(1, 60));
            set_config(thr, maxd);
            run_phase(250, thr, maxd);
            set_config(adg_pkg::THR_RESET, adg_pkg::MAXD_RESET);
            run_phase(250, adg_pkg::THR_RESET, adg_pkg::MAXD_RESET);
            thr  = THRW'($urandom_range(0, 4000));
            set_config(thr, 8'd3);
            run_phase(200, thr, 8'd3);
        end

        // drain and give the verdict
        calm = 1'b0;
        wait_idle();
        if (mon_fails == 0 && mon_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/adg_pkg.sv
sv/adg_ram.sv
sv/adg_div.sv
sv/av_desync_audio_drop_gate.sv
tb/sv/adg_gate_monitor.sv
tb/sv/tb_top.sv
